/* src/mdfp_pkg.sv */
// Shared types, constants and the Modbus CRC-16 byte update for the frame parser.
package mdfp_pkg;

    localparam int BYTE_W = 8;
    localparam int CRC_W  = 16;
    localparam int DIST_W = 15;
    localparam int MAXV_W = 13;
    localparam int POS_W  = 3;

    localparam logic [BYTE_W-1:0] ADDR_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] FUNC_BYTE = 8'h03;
    localparam logic [CRC_W-1:0]  CRC_INIT  = 16'hFFFF;
    localparam logic [CRC_W-1:0]  CRC_POLY  = 16'hA001;
    localparam logic [MAXV_W-1:0] MAXV_RST  = 13'd4096;

    // frame position codes: number of frame bytes already taken in
    localparam logic [POS_W-1:0] POS_HUNT   = 3'd0;
    localparam logic [POS_W-1:0] POS_FUNC   = 3'd1;
    localparam logic [POS_W-1:0] POS_COUNT  = 3'd2;
    localparam logic [POS_W-1:0] POS_DIST_H = 3'd3;
    localparam logic [POS_W-1:0] POS_DIST_L = 3'd4;
    localparam logic [POS_W-1:0] POS_CRC_LO = 3'd5;
    localparam logic [POS_W-1:0] POS_CRC_HI = 3'd6;

    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
    } byte_req_t;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic             fire;
    } core_status_t;

    // reflected CRC-16, one byte, unrolled over its eight bits
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-BYTE_W){1'b0}}, b};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* src/mdfp_in_reg.sv */
// Input register: captures one received byte request, holds it until the core takes it.
module mdfp_in_reg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mdfp_pkg::BYTE_W-1:0]  rx_byte,
    input  logic                         advance,
    output mdfp_pkg::byte_req_t          req
);
    import mdfp_pkg::*;

    logic              vld_reg;
    logic [BYTE_W-1:0] byte_reg;

    assign in_ready = !vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else if (in_ready)
            vld_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            byte_reg <= rx_byte;
    end

    assign req.vld  = vld_reg;
    assign req.data = byte_reg;
endmodule

/* src/mdfp_frame_core.sv */
// Frame tracker, CRC accumulator and result register of the parser.
module mdfp_frame_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mdfp_pkg::byte_req_t          req,
    input  logic [mdfp_pkg::MAXV_W-1:0]  max_val_cur,
    output logic                         advance,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mdfp_pkg::DIST_W-1:0]  distance,
    output mdfp_pkg::core_status_t       status
);
    import mdfp_pkg::*;

    logic [POS_W-1:0]  pos_reg,  pos_next;
    logic [CRC_W-1:0]  crc_reg,  crc_next;
    logic [CRC_W-1:0]  dist_hold_reg, dist_hold_next;
    logic [BYTE_W-1:0] crc_lo_reg,    crc_lo_next;
    logic              out_vld_reg,   out_vld_next;
    logic [DIST_W-1:0] dist_reg,      dist_next;
    logic              fire;
    logic [CRC_W-1:0]  crc_upd;
    logic [BYTE_W-1:0] b;

    assign advance = !out_vld_reg || out_ready;
    assign fire    = req.vld && advance;
    assign b       = req.data;
    assign crc_upd = crc_byte(crc_reg, b);

    always_comb
    begin
        pos_next       = pos_reg;
        crc_next       = crc_reg;
        dist_hold_next = dist_hold_reg;
        crc_lo_next    = crc_lo_reg;
        out_vld_next   = 1'b0;
        dist_next      = dist_reg;
        case (pos_reg)
            POS_FUNC:
            begin
                if (b == FUNC_BYTE)
                begin
                    crc_next = crc_upd;
                    pos_next = POS_COUNT;
                end
                else
                begin
                    crc_next = CRC_INIT;
                    pos_next = POS_HUNT;
                end
            end
            POS_COUNT:
            begin
                crc_next = crc_upd;
                pos_next = POS_DIST_H;
            end
            POS_DIST_H:
            begin
                dist_hold_next = {b, {BYTE_W{1'b0}}};
                crc_next       = crc_upd;
                pos_next       = POS_DIST_L;
            end
            POS_DIST_L:
            begin
                dist_hold_next = {dist_hold_reg[CRC_W-1:BYTE_W], b};
                crc_next       = crc_upd;
                pos_next       = POS_CRC_LO;
            end
            POS_CRC_LO:
            begin
                crc_lo_next = b;
                pos_next    = POS_CRC_HI;
            end
            POS_CRC_HI:
            begin
                if ({b, crc_lo_reg} == crc_reg)
                begin
                    out_vld_next = 1'b1;
                    // positive as a signed word: nonzero with sign bit clear
                    if (dist_hold_reg != '0 && !dist_hold_reg[CRC_W-1])
                        dist_next = dist_hold_reg[DIST_W-1:0];
                    else
                        dist_next = {{(DIST_W-MAXV_W){1'b0}}, max_val_cur};
                end
                crc_next = CRC_INIT;
                pos_next = POS_HUNT;
            end
            default:
            begin
                // hunting; an unused position code is treated the same
                if (b == ADDR_BYTE)
                begin
                    crc_next = crc_byte(CRC_INIT, b);
                    pos_next = POS_FUNC;
                end
                else
                begin
                    crc_next = CRC_INIT;
                    pos_next = POS_HUNT;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= POS_HUNT;
            crc_reg     <= CRC_INIT;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
            end
            if (advance)
                out_vld_reg <= fire && out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            dist_hold_reg <= dist_hold_next;
            crc_lo_reg    <= crc_lo_next;
        end
        if (fire && out_vld_next)
            dist_reg <= dist_next;
    end

    assign out_valid     = out_vld_reg;
    assign distance      = dist_reg;
    assign status.pos    = pos_reg;
    assign status.fire   = fire;
endmodule

/* src/modbus_distance_frame_parser_unit.sv */
// Top level of the Modbus RTU distance reply parser.
// Takes one received byte per cycle while in_ready is high and hunts for the 7-byte reply
// 01 03 nn dh dl cl ch, checking its Modbus CRC-16 over the first five bytes; a good frame
// yields one distance, the signed word dh:dl when positive, else max_val; a bad frame yields
// nothing. A byte passes through the input register, then the frame/CRC logic, which
// updates its state and loads the result register in the same cycle, so out_valid rises once
// the last byte of a good frame has moved from the input register into the result register.
// in_ready drops only while a result waits in the result register with out_ready low and
// a byte is already held. max_val is written through the cfg port, which is always ready,
// and resets to 4096.
module modbus_distance_frame_parser_unit (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [mdfp_pkg::BYTE_W-1:0]  rx_byte,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [mdfp_pkg::DIST_W-1:0]  distance,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [mdfp_pkg::MAXV_W-1:0]  max_val
);
    import mdfp_pkg::*;

    byte_req_t         req;
    core_status_t      status;
    logic              advance;
    logic [MAXV_W-1:0] max_val_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            max_val_reg <= MAXV_RST;
        else if (cfg_valid)
            max_val_reg <= max_val;
    end

    mdfp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .advance  (advance),
        .req      (req)
    );

    mdfp_frame_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .max_val_cur (max_val_reg),
        .advance     (advance),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance),
        .status      (status)
    );

    // a new result comes only from the last byte of a frame, and the hunt restarts
    a_result_from_last_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(status.fire) && $past(status.pos) == POS_CRC_HI
                             && status.pos == POS_HUNT)
        else $error("result not from last frame byte");

    // the input side only stalls behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready && req.vld)
        else $error("input stalled without a held result");

    // a reported distance is zero only when max_val is zero
    a_nonzero_dist: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> distance != '0 || max_val_reg == '0)
        else $error("zero distance with nonzero max_val");

    // the position only moves when a byte is processed
    a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !status.fire |=> $stable(status.pos))
        else $error("frame position moved without a byte");
endmodule

/* bench/tb_modbus_distance_frame_parser_unit.sv */
`timescale 1ns / 100ps
// Testbench for the Modbus RTU distance parser: frame stimulus, a predicting scoreboard and random stalls.
module tb_modbus_distance_frame_parser_unit;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_BYTES = 130;

    // Tracks the frame hunt byte by byte and keeps the distances still owed by the block.
    class frame_tracker;
        logic [mdfp_pkg::POS_W-1:0]  pos;
        logic [mdfp_pkg::CRC_W-1:0]  crc;
        logic [15:0]                 word;
        logic [mdfp_pkg::BYTE_W-1:0] crc_lo;
        logic [mdfp_pkg::MAXV_W-1:0] maxv;
        logic [mdfp_pkg::DIST_W-1:0] distance_due[$];
        int                          errors;

        function new();
            maxv = mdfp_pkg::MAXV_RST;
            word = '0;
            crc_lo = '0;
            errors = 0;
            restart();
        endfunction

        static function logic [15:0] crc_step(input logic [15:0] c, input logic [7:0] b);
            logic [15:0] acc;
            logic        lsb;
            acc = {c[15:8], c[7:0] ^ b};
            repeat (8)
            begin
                lsb = acc[0];
                acc = {1'b0, acc[15:1]};
                if (lsb)
                    acc = acc ^ mdfp_pkg::CRC_POLY;
            end
            return acc;
        endfunction

        function void restart();
            pos = mdfp_pkg::POS_HUNT;
            crc = mdfp_pkg::CRC_INIT;
        endfunction

        function void note_byte(input logic [7:0] b);
            logic [15:0] d;
            case (pos)
                mdfp_pkg::POS_FUNC:
                begin
                    if (b == mdfp_pkg::FUNC_BYTE)
                    begin
                        crc = crc_step(crc, b);
                        pos = mdfp_pkg::POS_COUNT;
                    end
                    else
                        restart();
                end
                mdfp_pkg::POS_COUNT:
                begin
                    crc = crc_step(crc, b);
                    pos = mdfp_pkg::POS_DIST_H;
                end
                mdfp_pkg::POS_DIST_H:
                begin
                    word = {b, 8'h00};
                    crc = crc_step(crc, b);
                    pos = mdfp_pkg::POS_DIST_L;
                end
                mdfp_pkg::POS_DIST_L:
                begin
                    word[7:0] = b;
                    crc = crc_step(crc, b);
                    pos = mdfp_pkg::POS_CRC_LO;
                end
                mdfp_pkg::POS_CRC_LO:
                begin
                    crc_lo = b;
                    pos = mdfp_pkg::POS_CRC_HI;
                end
                mdfp_pkg::POS_CRC_HI:
                begin
                    if ({b, crc_lo} == crc)
                    begin
                        // only 1..0x7FFF counts as a positive reading
                        if (word != 16'h0000 && !word[15])
                            d = word;
                        else
                            d = {3'b000, maxv};
                        distance_due.push_back(d[mdfp_pkg::DIST_W-1:0]);
                    end
                    restart();
                end
                default:
                begin
                    restart();
                    if (b == mdfp_pkg::ADDR_BYTE)
                    begin
                        crc = crc_step(crc, b);
                        pos = mdfp_pkg::POS_FUNC;
                    end
                end
            endcase
        endfunction

        function void check_distance(input logic [mdfp_pkg::DIST_W-1:0] got);
            logic [mdfp_pkg::DIST_W-1:0] want;
            if (distance_due.size() == 0)
            begin
                $display("%0t: unexpected distance, expected none, actual %0d", $time, got);
                errors++;
            end
            else
            begin
                want = distance_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: distance mismatch, expected %0d, actual %0d", $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return distance_due.size();
        endfunction
    endclass

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic [mdfp_pkg::BYTE_W-1:0]   rx_byte;
    logic                          out_valid;
    logic                          out_ready;
    logic [mdfp_pkg::DIST_W-1:0]   distance;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mdfp_pkg::MAXV_W-1:0]   max_val;

    frame_tracker sb;
    bit           hold_req;
    bit           tx_calm;
    bit           rx_calm;
    int           frame_bytes;
    int           idle_cycles;

    modbus_distance_frame_parser_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .distance  (distance),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .max_val   (max_val)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // mostly short gaps, now and then a long one
    function automatic int unsigned gap_len(input bit calm);
        int unsigned r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] pick_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 16'h0000;
        if (r < 18)
            return {1'b1, 15'($urandom)};
        if (r < 22)
            return 16'h0001;
        if (r < 26)
            return 16'h7FFF;
        if (r < 28)
            return 16'h8000;
        if (r < 30)
            return 16'hFFFF;
        return 16'($urandom_range(1, 32767));
    endfunction

    function automatic logic [7:0] pick_count();
        if ($urandom_range(0, 4) != 0)
            return 8'h02;
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_byte(input logic [7:0] b);
        int unsigned n;
        n = gap_len(tx_calm);
        if (n > 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid = 1'b1;
        rx_byte = b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // cut: bytes actually sent; bad_func replaces the function code
    task automatic send_frame(input logic [15:0] word, input logic [7:0] cnt, input int cut,
                              input bit bad_crc, input bit bad_func);
        logic [7:0]  f [0:6];
        logic [15:0] c;
        int unsigned k;
        f[0] = mdfp_pkg::ADDR_BYTE;
        f[1] = mdfp_pkg::FUNC_BYTE;
        f[2] = cnt;
        f[3] = word[15:8];
        f[4] = word[7:0];
        c = mdfp_pkg::CRC_INIT;
        for (int i = 0; i < 5; i++)
            c = frame_tracker::crc_step(c, f[i]);
        f[5] = c[7:0];
        f[6] = c[15:8];
        if (bad_crc)
        begin
            k = $urandom_range(2, 6);
            f[k] = f[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        if (bad_func)
        begin
            if ($urandom_range(0, 1) == 0)
                f[1] = mdfp_pkg::ADDR_BYTE;
            else
            begin
                do
                    f[1] = 8'($urandom_range(0, 255));
                while (f[1] == mdfp_pkg::FUNC_BYTE);
            end
        end
        for (int i = 0; i < cut; i++)
            send_byte(f[i]);
        frame_bytes += cut;
    endtask

    task automatic run_phase(input int n_bytes);
        int          target;
        int unsigned r;
        int unsigned k;
        target = frame_bytes + n_bytes;
        while (frame_bytes < target)
        begin
            tx_calm = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 99);
            if (r < 70)
                send_frame(pick_word(), pick_count(), 7, 1'b0, 1'b0);
            else if (r < 80)
                send_frame(pick_word(), pick_count(), 7, 1'b1, 1'b0);
            else if (r < 87)
                send_frame(pick_word(), pick_count(), $urandom_range(1, 6), 1'b0, 1'b0);
            else if (r < 93)
                send_frame(pick_word(), pick_count(), 2, 1'b0, 1'b1);
            else
            begin
                k = $urandom_range(1, 5);
                repeat (k) send_byte(8'($urandom_range(0, 255)));
                frame_bytes += int'(k);
            end
        end
    endtask

    // stop sending and wait until every owed distance has come out
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_max(input logic [mdfp_pkg::MAXV_W-1:0] v);
        @(negedge clk);
        cfg_valid = 1'b1;
        max_val = v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.maxv = v;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial
    begin
        int unsigned n;
        bit          hold_done;
        out_ready = 1'b0;
        rx_calm = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 63) == 0)
                rx_calm = !rx_calm;
            if (hold_req && !hold_done)
            begin
                out_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_done = 1'b1;
            end
            else
            begin
                n = gap_len(rx_calm);
                if (n == 0)
                    out_ready = 1'b1;
                else
                begin
                    out_ready = 1'b0;
                    repeat (n - 1) @(negedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
                sb.note_byte(rx_byte);
            if (out_valid && out_ready)
                sb.check_distance(distance);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        rx_byte = '0;
        cfg_valid = 1'b0;
        max_val = '0;
        hold_req = 1'b0;
        tx_calm = 1'b0;
        frame_bytes = 0;
        sb = new();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: smallest positive, all-ones word, bad function code, largest positive,
        // zero word, CRC mismatch
        send_frame(16'h0001, 8'h00, 7, 1'b0, 1'b0);
        send_frame(16'hFFFF, 8'hFF, 7, 1'b0, 1'b0);
        send_byte(mdfp_pkg::ADDR_BYTE);
        send_byte(mdfp_pkg::ADDR_BYTE);
        send_frame(16'h7FFF, 8'h02, 7, 1'b0, 1'b0);
        send_frame(16'h0000, 8'h02, 7, 1'b0, 1'b0);
        send_frame(16'h8000, 8'h02, 7, 1'b1, 1'b0);
        settle();

        write_max(13'd1);
        run_phase(PHASE_BYTES);
        settle();

        // max_val of zero while the receiver holds off and the input backs up
        write_max(13'd0);
        hold_req = 1'b1;
        run_phase(PHASE_BYTES);
        settle();

        write_max(13'($urandom_range(1, 4096)));
        run_phase(PHASE_BYTES);
        settle();

        write_max(13'd4096);
        run_phase(PHASE_BYTES);
        settle();

        write_max(13'($urandom_range(1, 4096)));
        run_phase(PHASE_BYTES);
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
